FILE: rtl/core/palr_pkg.sv
`timescale 1ns / 1ps

package palr_pkg;

    localparam int NVAL = 11;
    localparam logic [23:0] SPACING_RESET = 24'd4096;
    localparam logic [15:0] QUAT_ONE = 16'd16384;

    localparam int DVD_W = 64;
    localparam int DVS_W = 34;
    localparam int RAD_W = 66;
    localparam int ROOT_W = 33;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic signed [15:0] quat_w;
        logic signed [15:0] speed_long;
        logic signed [15:0] speed_lat;
        logic signed [15:0] accel;
        logic signed [15:0] yaw_rate;
        logic               final_point;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] out_x;
        logic signed [31:0] out_y;
        logic signed [31:0] out_z;
        logic signed [15:0] out_qx;
        logic signed [15:0] out_qy;
        logic signed [15:0] out_qz;
        logic signed [15:0] out_qw;
        logic signed [15:0] out_speed_long;
        logic signed [15:0] out_speed_lat;
        logic signed [15:0] out_accel;
        logic signed [15:0] out_yaw_rate;
        logic               run_end;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DVD_W-1:0] quot;
        logic [DVS_W-1:0] rem;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [RAD_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

FILE: rtl/core/palr_div.sv
`timescale 1ns / 1ps

module palr_div
    import palr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic             r_busy;
    logic             r_done;
    logic [5:0]       r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DVD_W-1:0] r_quot;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;

    logic [DVS_W:0] rem2;
    logic [DVS_W:0] diff;
    logic           ge;

    assign rem2 = {r_rem, r_dvd[DVD_W-1]};
    assign ge   = rem2 >= {1'b0, r_dvs};
    assign diff = rem2 - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd63;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_dvd  <= i_req.dividend;
            r_dvs  <= i_req.divisor;
            r_rem  <= '0;
            r_quot <= '0;
        end else if (r_busy) begin
            r_dvd  <= {r_dvd[DVD_W-2:0], 1'b0};
            r_quot <= {r_quot[DVD_W-2:0], ge};
            r_rem  <= ge ? diff[DVS_W-1:0] : rem2[DVS_W-1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

endmodule

FILE: rtl/core/palr_sqrt.sv
`timescale 1ns / 1ps

module palr_sqrt
    import palr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_sqrt_req i_req,
    output t_sqrt_rsp o_rsp
);

    logic              r_busy;
    logic              r_done;
    logic [5:0]        r_cnt;
    logic [RAD_W-1:0]  r_rad;
    logic [ROOT_W-1:0] r_root;
    logic [ROOT_W+1:0] r_rem;

    logic [ROOT_W+3:0] rem4;
    logic [ROOT_W+3:0] trial;
    logic [ROOT_W+3:0] diff;
    logic              ge;

    assign rem4  = {r_rem, r_rad[RAD_W-1:RAD_W-2]};
    assign trial = {2'b00, r_root, 2'b01};
    assign ge    = rem4 >= trial;
    assign diff  = rem4 - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'(ROOT_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rad  <= i_req.radicand;
            r_root <= '0;
            r_rem  <= '0;
        end else if (r_busy) begin
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_rem  <= ge ? diff[ROOT_W+1:0] : rem4[ROOT_W+1:0];
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("square root restarted while busy");

endmodule

FILE: rtl/core/path_arc_length_resampler.sv
// a first point or a point at zero spacing goes through ST_PASS to the output register, marked as a run end
// a segment's length takes one square root, and one division more when targets are skipped
// each resampled point takes up to five divisions on the shared divider, one square root
//   when its quaternion is not zero, and steps of the shared 32x32 multiplier
// throughput: one point at a time; ready stays low until its results are handed to the output
// reset: synchronous active low, clears control state and sets spacing to 4096
`timescale 1ns / 1ps

module path_arc_length_resampler
    import palr_pkg::*;
#(
    parameter int MAX_PER_SEGMENT = 63
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [23:0] i_cfg_wr_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  t_in_item    i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output t_out_item   o_out_data
);

    localparam int CW = $clog2(MAX_PER_SEGMENT + 1);
    localparam logic [CW:0] MAX_W = (CW + 1)'(MAX_PER_SEGMENT);

    localparam logic [3:0] F_X  = 4'd0;
    localparam logic [3:0] F_Y  = 4'd1;
    localparam logic [3:0] F_Z  = 4'd2;
    localparam logic [3:0] F_QX = 4'd3;
    localparam logic [3:0] F_QY = 4'd4;
    localparam logic [3:0] F_QZ = 4'd5;
    localparam logic [3:0] F_QW = 4'd6;
    localparam logic [3:0] F_VL = 4'd7;
    localparam logic [3:0] F_VT = 4'd8;
    localparam logic [3:0] F_AC = 4'd9;
    localparam logic [3:0] F_YR = 4'd10;

    typedef enum logic [14:0] {
        ST_IDLE = 15'b000000000000001,
        ST_PASS = 15'b000000000000010,
        ST_SQ   = 15'b000000000000100,
        ST_LEN  = 15'b000000000001000,
        ST_CHK  = 15'b000000000010000,
        ST_DIVR = 15'b000000000100000,
        ST_LERP = 15'b000000001000000,
        ST_QSQ  = 15'b000000010000000,
        ST_QRT  = 15'b000000100000000,
        ST_QDIV = 15'b000001000000000,
        ST_EMIT = 15'b000010000000000,
        ST_ADJ  = 15'b000100000000000,
        ST_MOD  = 15'b001000000000000,
        ST_FIN  = 15'b010000000000000,
        ST_APP  = 15'b100000000000000
    } t_state;

    function automatic logic signed [31:0] fld(input t_in_item p, input logic [3:0] k);
        logic signed [31:0] v;
        unique case (k)
            F_X:     v = p.pos_x;
            F_Y:     v = p.pos_y;
            F_Z:     v = p.pos_z;
            F_QX:    v = 32'(p.quat_x);
            F_QY:    v = 32'(p.quat_y);
            F_QZ:    v = 32'(p.quat_z);
            F_QW:    v = 32'(p.quat_w);
            F_VL:    v = 32'(p.speed_long);
            F_VT:    v = 32'(p.speed_lat);
            F_AC:    v = 32'(p.accel);
            F_YR:    v = 32'(p.yaw_rate);
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic t_out_item pass_out(input t_in_item p);
        t_out_item o;
        o.out_x          = p.pos_x;
        o.out_y          = p.pos_y;
        o.out_z          = p.pos_z;
        o.out_qx         = p.quat_x;
        o.out_qy         = p.quat_y;
        o.out_qz         = p.quat_z;
        o.out_qw         = p.quat_w;
        o.out_speed_long = p.speed_long;
        o.out_speed_lat  = p.speed_lat;
        o.out_accel      = p.accel;
        o.out_yaw_rate   = p.yaw_rate;
        o.run_end        = 1'b1;
        return o;
    endfunction

    t_state             r_state, n_state;
    logic               r_ph, n_ph;
    logic [3:0]         r_idx, n_idx;
    t_in_item           r_cur, n_cur;
    t_in_item           r_prev, n_prev;
    logic               r_have, n_have;
    logic [34:0]        r_t, n_t;
    logic [32:0]        r_len, n_len;
    logic [CW-1:0]      r_cnt, n_cnt;
    logic [64:0]        r_sum, n_sum;
    logic [30:0]        r_ratio, n_ratio;
    logic [24:0]        r_root, n_root;
    logic signed [31:0] r_v [NVAL];
    logic signed [31:0] n_v [NVAL];
    logic [23:0]        r_spacing;
    logic signed [31:0] r_lx, n_lx;
    logic signed [31:0] r_ly, n_ly;
    t_out_item          r_out, n_out;
    logic               r_oval, n_oval;
    logic [63:0]        r_prod;

    t_div_req  div_req;
    t_div_rsp  div_rsp;
    t_sqrt_req sq_req;
    t_sqrt_rsp sq_rsp;

    logic               in_acc;
    logic               out_free;
    logic signed [31:0] cur_k;
    logic signed [31:0] prev_k;
    logic signed [32:0] d_k;
    logic [32:0]        d_abs;
    logic [31:0]        d_mag;
    logic [63:0]        rnd;
    logic [31:0]        lerp_v;
    logic [3:0]         qi;
    logic signed [15:0] qv;
    logic [15:0]        q_mag;
    logic [15:0]        m_sat;
    logic signed [15:0] q_new;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [64:0]        sum_next;
    logic [34:0]        t_step;
    logic               more;

    palr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    palr_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sq_req),
        .o_rsp   (sq_rsp)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_oval || i_out_ready;
    assign o_out_valid = r_oval;
    assign o_out_data  = r_out;

    assign cur_k  = fld(r_cur, r_idx);
    assign prev_k = fld(r_prev, r_idx);
    assign d_k    = 33'(cur_k) - 33'(prev_k);
    assign d_abs  = d_k[32] ? 33'(-d_k) : 33'(d_k);
    assign d_mag  = d_abs[31:0];
    assign rnd    = r_prod + 64'h0000_0000_2000_0000;
    assign lerp_v = d_k[32] ? 32'(prev_k) - rnd[61:30] : 32'(prev_k) + rnd[61:30];

    assign qi    = F_QX + {2'b00, r_idx[1:0]};
    assign qv    = r_v[qi][15:0];
    assign q_mag = qv[15] ? 16'(-qv) : 16'(qv);
    assign m_sat = (div_rsp.quot > 64'(QUAT_ONE)) ? QUAT_ONE : div_rsp.quot[15:0];
    assign q_new = qv[15] ? -signed'(m_sat) : signed'(m_sat);

    assign sum_next = r_sum + 65'(r_prod);
    assign t_step   = r_t + 35'(r_spacing);
    assign more     = ((t_step <= 35'(r_len)) && (({1'b0, r_cnt} + 1'b1) < MAX_W))
                   || (r_cur.final_point && ((r_cur.pos_x != r_v[0]) || (r_cur.pos_y != r_v[1])));

    // shared multiplier operand select
    always_comb begin
        unique case (r_state)
            ST_SQ: begin
                mul_a = d_mag;
                mul_b = d_mag;
            end
            ST_LERP: begin
                mul_a = d_mag;
                mul_b = {1'b0, r_ratio};
            end
            ST_QSQ: begin
                mul_a = {16'd0, q_mag};
                mul_b = {16'd0, q_mag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
    end

    always_comb begin
        n_state = r_state;
        n_ph    = r_ph;
        n_idx   = r_idx;
        n_cur   = r_cur;
        n_prev  = r_prev;
        n_have  = r_have;
        n_t     = r_t;
        n_len   = r_len;
        n_cnt   = r_cnt;
        n_sum   = r_sum;
        n_ratio = r_ratio;
        n_root  = r_root;
        n_v     = r_v;
        n_lx    = r_lx;
        n_ly    = r_ly;
        n_out   = r_out;
        n_oval  = r_oval && !i_out_ready;
        div_req = '0;
        sq_req  = '0;

        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    n_cur   = i_in_data;
                    n_idx   = '0;
                    n_ph    = 1'b0;
                    n_sum   = '0;
                    n_state = ((r_spacing == 24'd0) || !r_have) ? ST_PASS : ST_SQ;
                end
            end
            ST_PASS: begin
                if (out_free) begin
                    n_out   = pass_out(r_cur);
                    n_oval  = 1'b1;
                    n_lx    = r_cur.pos_x;
                    n_ly    = r_cur.pos_y;
                    n_t     = 35'(r_spacing);
                    n_state = ST_IDLE;
                end
            end
            ST_SQ: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_sum = sum_next;
                    n_ph  = 1'b0;
                    if (r_idx == F_Y) begin
                        n_idx   = '0;
                        n_state = ST_LEN;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            ST_LEN: begin
                if (!r_ph) begin
                    sq_req.start    = 1'b1;
                    sq_req.radicand = {1'b0, r_sum};
                    n_ph            = 1'b1;
                end else if (sq_rsp.done) begin
                    n_len   = sq_rsp.root;
                    n_t     = (r_t == '0) ? 35'(r_spacing) : r_t;
                    n_cnt   = '0;
                    n_ph    = 1'b0;
                    n_state = ST_CHK;
                end
            end
            ST_CHK: begin
                if ((r_t <= 35'(r_len)) && ({1'b0, r_cnt} < MAX_W)) begin
                    n_state = ST_DIVR;
                end else begin
                    n_state = ST_ADJ;
                end
            end
            ST_DIVR: begin
                if (!r_ph) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {r_t[33:0], 30'd0};
                    div_req.divisor  = {1'b0, r_len};
                    n_ph             = 1'b1;
                end else if (div_rsp.done) begin
                    n_ratio = div_rsp.quot[30:0];
                    n_ph    = 1'b0;
                    n_idx   = '0;
                    n_state = ST_LERP;
                end
            end
            ST_LERP: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_v[r_idx] = signed'(lerp_v);
                    n_ph       = 1'b0;
                    if (r_idx == F_YR) begin
                        n_idx   = '0;
                        n_sum   = '0;
                        n_state = ST_QSQ;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            ST_QSQ: begin
                if (!r_ph) begin
                    n_ph = 1'b1;
                end else begin
                    n_sum = sum_next;
                    n_ph  = 1'b0;
                    if (r_idx == 4'd3) begin
                        n_idx   = '0;
                        n_state = (sum_next == '0) ? ST_EMIT : ST_QRT;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            ST_QRT: begin
                if (!r_ph) begin
                    sq_req.start    = 1'b1;
                    sq_req.radicand = {17'd0, r_sum[32:0], 16'd0};
                    n_ph            = 1'b1;
                end else if (sq_rsp.done) begin
                    n_root  = sq_rsp.root[24:0];
                    n_ph    = 1'b0;
                    n_idx   = '0;
                    n_state = ST_QDIV;
                end
            end
            ST_QDIV: begin
                if (!r_ph) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'({q_mag, 22'd0}) + 64'(r_root[24:1]);
                    div_req.divisor  = 34'(r_root);
                    n_ph             = 1'b1;
                end else if (div_rsp.done) begin
                    n_v[qi] = 32'(q_new);
                    n_ph    = 1'b0;
                    if (r_idx == 4'd3) begin
                        n_idx   = '0;
                        n_state = ST_EMIT;
                    end else begin
                        n_idx = r_idx + 4'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    n_out.out_x          = r_v[F_X];
                    n_out.out_y          = r_v[F_Y];
                    n_out.out_z          = r_v[F_Z];
                    n_out.out_qx         = r_v[F_QX][15:0];
                    n_out.out_qy         = r_v[F_QY][15:0];
                    n_out.out_qz         = r_v[F_QZ][15:0];
                    n_out.out_qw         = r_v[F_QW][15:0];
                    n_out.out_speed_long = r_v[F_VL][15:0];
                    n_out.out_speed_lat  = r_v[F_VT][15:0];
                    n_out.out_accel      = r_v[F_AC][15:0];
                    n_out.out_yaw_rate   = r_v[F_YR][15:0];
                    n_out.run_end        = !more;
                    n_oval               = 1'b1;
                    n_lx                 = r_v[F_X];
                    n_ly                 = r_v[F_Y];
                    n_t                  = t_step;
                    n_cnt                = r_cnt + 1'b1;
                    n_state              = ST_CHK;
                end
            end
            ST_ADJ: begin
                if (r_t <= 35'(r_len)) begin
                    n_ph    = 1'b0;
                    n_state = ST_MOD;
                end else begin
                    n_t     = r_t - 35'(r_len);
                    n_state = ST_FIN;
                end
            end
            ST_MOD: begin
                // targets left past the per-segment cap are skipped
                if (!r_ph) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = 64'(r_len - r_t[32:0]);
                    div_req.divisor  = 34'(r_spacing);
                    n_ph             = 1'b1;
                end else if (div_rsp.done) begin
                    n_t     = 35'(r_spacing) - 35'(div_rsp.rem);
                    n_ph    = 1'b0;
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                if (r_cur.final_point && ((r_cur.pos_x != r_lx) || (r_cur.pos_y != r_ly))) begin
                    n_state = ST_APP;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_APP: begin
                if (out_free) begin
                    n_out   = pass_out(r_cur);
                    n_oval  = 1'b1;
                    n_lx    = r_cur.pos_x;
                    n_ly    = r_cur.pos_y;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // end of the point: keep it as the start of the next segment
        if ((r_state != ST_IDLE) && (n_state == ST_IDLE)) begin
            n_have = !r_cur.final_point;
            if (!r_cur.final_point) begin
                n_prev = r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ph      <= 1'b0;
            r_idx     <= '0;
            r_have    <= 1'b0;
            r_t       <= '0;
            r_cnt     <= '0;
            r_spacing <= SPACING_RESET;
            r_lx      <= '0;
            r_ly      <= '0;
            r_oval    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            r_idx   <= n_idx;
            r_have  <= n_have;
            r_t     <= n_t;
            r_cnt   <= n_cnt;
            r_lx    <= n_lx;
            r_ly    <= n_ly;
            r_oval  <= n_oval;
            if (i_cfg_wr_en) begin
                r_spacing <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur   <= n_cur;
        r_prev  <= n_prev;
        r_len   <= n_len;
        r_sum   <= n_sum;
        r_ratio <= n_ratio;
        r_root  <= n_root;
        r_v     <= n_v;
        r_out   <= n_out;
    end

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !o_in_ready)
        else $error("input taken again before point finished");

    a_cnt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_cnt} <= MAX_W))
        else $error("segment point count above cap");

    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIVR && r_ph && div_rsp.done) |-> (div_rsp.quot <= 64'h4000_0000))
        else $error("interpolation ratio above one");

    a_emit_in_seg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> (r_t <= 35'(r_len)))
        else $error("emitted target beyond segment end");

endmodule

FILE: tb/sv/path_arc_length_resampler_test.sv
`timescale 1ns / 1ps

module path_arc_length_resampler_test
    import palr_pkg::*;
();

    typedef longint t_point [NVAL];

    localparam int MAX_SEG = 63;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [23:0] i_cfg_wr_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    t_in_item    i_in_data = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    t_out_item   o_out_data;

    path_arc_length_resampler #(.MAX_PER_SEGMENT(MAX_SEG)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_in_data     (i_in_data),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_out_data    (o_out_data)
    );

    t_in_item  pending_points[$];
    t_out_item expected_points[$];
    int        error_count = 0;
    int        accepted_count = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        hold_at = -1;
    int        hold_left = 0;

    // predictor state
    logic [23:0] spacing_m = SPACING_RESET;
    bit          have_prev_m = 1'b0;
    t_point      prev_m = '{default: 0};
    logic [63:0] target_m = '0;
    longint      last_x_m = 0;
    longint      last_y_m = 0;

    // random walk of the stimulus
    longint walk_x = 0, walk_y = 0, walk_z = 0;
    bit     walk_new = 1'b1;

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("[path_arc_length_resampler] ERROR");
        $finish;
    end

    function automatic logic [32:0] int_sqrt(logic [65:0] x);
        logic [67:0] rem, trial, root;
        rem = '0;
        root = '0;
        for (int i = 32; i >= 0; i--) begin
            rem = (rem << 2) | x[2*i +: 2];
            trial = (root << 2) | 68'd1;
            if (rem >= trial) begin
                rem = rem - trial;
                root = (root << 1) | 68'd1;
            end else begin
                root = root << 1;
            end
        end
        return root[32:0];
    endfunction

    function automatic logic [63:0] mag(longint v);
        return v < 0 ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint lerp(longint a, longint b, logic [63:0] r);
        longint d;
        logic [127:0] p;
        longint q;
        d = b - a;
        p = 128'(mag(d)) * 128'(r) + (128'd1 << 29);
        q = longint'(p >> 30);
        return d >= 0 ? a + q : a - q;
    endfunction

    task automatic queue_input(t_in_item it);
        pending_points.insert(pending_points.size(), it);
    endtask

    task automatic push_point(t_point v);
        t_out_item res;
        res.out_x = v[0][31:0];
        res.out_y = v[1][31:0];
        res.out_z = v[2][31:0];
        res.out_qx = v[3][15:0];
        res.out_qy = v[4][15:0];
        res.out_qz = v[5][15:0];
        res.out_qw = v[6][15:0];
        res.out_speed_long = v[7][15:0];
        res.out_speed_lat = v[8][15:0];
        res.out_accel = v[9][15:0];
        res.out_yaw_rate = v[10][15:0];
        res.run_end = 1'b0;
        expected_points.insert(expected_points.size(), res);
        last_x_m = v[0];
        last_y_m = v[1];
    endtask

    task automatic predict_resampled(t_in_item it);
        t_point cur, v;
        logic [63:0] dx, dy, r, s, m, root;
        logic [65:0] sq;
        logic [63:0] len;
        int n, cnt;
        cur[0] = longint'(it.pos_x);
        cur[1] = longint'(it.pos_y);
        cur[2] = longint'(it.pos_z);
        cur[3] = longint'(it.quat_x);
        cur[4] = longint'(it.quat_y);
        cur[5] = longint'(it.quat_z);
        cur[6] = longint'(it.quat_w);
        cur[7] = longint'(it.speed_long);
        cur[8] = longint'(it.speed_lat);
        cur[9] = longint'(it.accel);
        cur[10] = longint'(it.yaw_rate);
        n = 0;
        if (spacing_m == 0) begin
            push_point(cur);
            n++;
            target_m = '0;
        end else if (!have_prev_m) begin
            push_point(cur);
            n++;
            target_m = 64'(spacing_m);
        end else begin
            dx = mag(cur[0] - prev_m[0]);
            dy = mag(cur[1] - prev_m[1]);
            sq = 66'(dx) * 66'(dx) + 66'(dy) * 66'(dy);
            len = 64'(int_sqrt(sq));
            cnt = 0;
            if (target_m == 0) target_m = 64'(spacing_m);
            while (target_m <= len && cnt < MAX_SEG) begin
                r = 64'((128'(target_m) << 30) / 128'(len));
                for (int j = 0; j < NVAL; j++) v[j] = lerp(prev_m[j], cur[j], r);
                s = 0;
                for (int j = 3; j < 7; j++) s += mag(v[j]) * mag(v[j]);
                if (s != 0) begin
                    root = 64'(int_sqrt(66'(s) << 16));
                    for (int j = 3; j < 7; j++) begin
                        m = ((mag(v[j]) << 22) + root / 2) / root;
                        if (m > 64'(QUAT_ONE)) m = 64'(QUAT_ONE);
                        v[j] = v[j] < 0 ? -longint'(m) : longint'(m);
                    end
                end
                push_point(v);
                n++;
                cnt++;
                target_m += 64'(spacing_m);
            end
            if (target_m <= len)
                target_m += ((len - target_m) / 64'(spacing_m) + 1) * 64'(spacing_m);
            target_m -= len;
            if (it.final_point && (cur[0] != last_x_m || cur[1] != last_y_m)) begin
                push_point(cur);
                n++;
            end
        end
        if (it.final_point) begin
            have_prev_m = 1'b0;
        end else begin
            have_prev_m = 1'b1;
            prev_m = cur;
        end
        if (n > 0) expected_points[$].run_end = 1'b1;
    endtask

    function automatic t_in_item make_point(longint x, longint y, longint z, bit fin);
        t_in_item it;
        it.pos_x = x[31:0];
        it.pos_y = y[31:0];
        it.pos_z = z[31:0];
        if ($urandom_range(9) == 0) begin
            it.quat_x = '0;
            it.quat_y = '0;
            it.quat_z = '0;
            it.quat_w = '0;
        end else begin
            it.quat_x = 16'($signed($urandom_range(32768)) - 16384);
            it.quat_y = 16'($signed($urandom_range(32768)) - 16384);
            it.quat_z = 16'($signed($urandom_range(32768)) - 16384);
            it.quat_w = 16'($signed($urandom_range(32768)) - 16384);
        end
        it.speed_long = 16'($urandom());
        it.speed_lat = 16'($urandom());
        it.accel = 16'($urandom());
        it.yaw_rate = 16'($urandom());
        it.final_point = fin;
        return it;
    endfunction

    task automatic add_walk(int count, int step);
        bit fin;
        for (int k = 0; k < count; k++) begin
            if (walk_new) begin
                walk_x = longint'($signed($urandom()));
                walk_y = longint'($signed($urandom()));
                walk_z = longint'($signed($urandom()));
            end else if ($urandom_range(9) != 0) begin
                walk_x += longint'($urandom_range(2 * step)) - step;
                walk_y += longint'($urandom_range(2 * step)) - step;
                walk_z += longint'($urandom_range(2 * step)) - step;
            end
            fin = $urandom_range(7) == 0;
            queue_input(make_point(walk_x, walk_y, walk_z, fin));
            walk_new = fin;
        end
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || i_in_valid || expected_points.size() != 0)
            @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic write_spacing(logic [23:0] value);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= value;
        spacing_m = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic check_field(string name, longint exp_v, longint got_v);
        if (exp_v != got_v) begin
            error_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
        end
    endtask

    // transfer on the input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                predict_resampled(i_in_data);
                accepted_count++;
            end
            if (!i_in_valid || o_in_ready) begin
                if (pending_points.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in_valid <= 1'b1;
                    i_in_data <= pending_points.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // transfer on the output side
    always @(posedge i_clk) begin
        t_out_item exp_p;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (expected_points.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result, actual %p", $time, o_out_data);
                end else begin
                    exp_p = expected_points.pop_front();
                    check_field("out_x", exp_p.out_x, o_out_data.out_x);
                    check_field("out_y", exp_p.out_y, o_out_data.out_y);
                    check_field("out_z", exp_p.out_z, o_out_data.out_z);
                    check_field("out_qx", exp_p.out_qx, o_out_data.out_qx);
                    check_field("out_qy", exp_p.out_qy, o_out_data.out_qy);
                    check_field("out_qz", exp_p.out_qz, o_out_data.out_qz);
                    check_field("out_qw", exp_p.out_qw, o_out_data.out_qw);
                    check_field("out_speed_long", exp_p.out_speed_long,
                                o_out_data.out_speed_long);
                    check_field("out_speed_lat", exp_p.out_speed_lat,
                                o_out_data.out_speed_lat);
                    check_field("out_accel", exp_p.out_accel, o_out_data.out_accel);
                    check_field("out_yaw_rate", exp_p.out_yaw_rate, o_out_data.out_yaw_rate);
                    check_field("run_end", exp_p.run_end, o_out_data.run_end);
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                i_out_ready <= 1'b0;
            end else if (accepted_count == hold_at) begin
                hold_left <= 3000;
                hold_at <= -1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= $urandom_range(99) >= recv_stall_pct;
            end
        end
    end

    initial begin
        t_in_item it;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // single point path, then a path over the special cases
        queue_input(make_point(100, 200, 300, 1'b1));
        queue_input(make_point(0, 0, 0, 1'b0));
        queue_input(make_point(0, 0, 5, 1'b0));
        queue_input(make_point(10000, 0, 0, 1'b0));
        it = make_point(10000, 0, 0, 1'b0);
        it.quat_x = '0; it.quat_y = '0; it.quat_z = '0; it.quat_w = '0;
        queue_input(it);
        it = make_point(10000, 20000, 0, 1'b0);
        it.quat_x = '0; it.quat_y = '0; it.quat_z = '0; it.quat_w = '0;
        queue_input(it);
        it = make_point(10000, 430000, -7, 1'b0);
        it.quat_x = 16'sd16384; it.quat_y = -16'sd16384; it.quat_z = 16'sd16384;
        it.quat_w = -16'sd16384;
        it.speed_long = 16'h8000; it.speed_lat = 16'h7fff;
        it.accel = 16'h8000; it.yaw_rate = 16'h7fff;
        queue_input(it);
        queue_input(make_point(0, 0, 0, 1'b0));
        // final point past the last target is appended
        queue_input(make_point(8192, 0, 0, 1'b1));
        queue_input(make_point(0, 0, 0, 1'b0));
        queue_input(make_point(5000, 1, 0, 1'b1));
        wait_drained();

        write_spacing(24'd0);
        queue_input(make_point(-2147483648, 2147483647, 1, 1'b0));
        queue_input(make_point(2147483647, -2147483648, 2, 1'b0));
        queue_input(make_point(5, 5, 5, 1'b1));
        wait_drained();

        write_spacing(24'hffffff);
        queue_input(make_point(-2147483648, -2147483648, -2147483648, 1'b0));
        queue_input(make_point(2147483647, 2147483647, 2147483647, 1'b0));
        queue_input(make_point(2147483647, 2147483647, 0, 1'b1));
        wait_drained();

        write_spacing(24'd1);
        queue_input(make_point(0, 0, 0, 1'b0));
        queue_input(make_point(3, 4, 0, 1'b0));
        queue_input(make_point(3, 4, 0, 1'b1));
        wait_drained();

        // random paths, spacing changes mid-path between phases
        write_spacing(24'd4096);
        add_walk(15, 3 * 4096);
        hold_at = accepted_count + 5;
        wait_drained();

        send_idle_pct = 50;
        write_spacing(24'($urandom_range(500, 8000)));
        add_walk(15, 3 * int'(spacing_m));
        wait_drained();

        send_idle_pct = 0;
        recv_stall_pct = 50;
        write_spacing(24'($urandom_range(500, 8000)));
        add_walk(15, 3 * int'(spacing_m));
        wait_drained();

        send_idle_pct = 7;
        recv_stall_pct = 7;
        write_spacing(24'($urandom_range(500, 8000)));
        add_walk(15, 3 * int'(spacing_m));
        wait_drained();

        recv_stall_pct = 50;
        write_spacing(24'hffffff);
        add_walk(12, 1 << 25);
        wait_drained();

        send_idle_pct = 50;
        recv_stall_pct = 0;
        write_spacing(24'd1);
        add_walk(12, 4);
        wait_drained();

        send_idle_pct = 7;
        recv_stall_pct = 7;
        write_spacing(24'($urandom_range(1, 20000)));
        add_walk(15, 3 * int'(spacing_m));
        wait_drained();

        if (error_count == 0) begin
            $display("[path_arc_length_resampler] OK");
        end else begin
            $display("[path_arc_length_resampler] ERROR");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/palr_pkg.sv
rtl/core/palr_div.sv
rtl/core/palr_sqrt.sv
rtl/core/path_arc_length_resampler.sv
tb/sv/path_arc_length_resampler_test.sv
